[rtl/rrjd_pkg.sv]
// Shared types, field widths and codes for the round-robin job dispatcher.
package rrjd_pkg;

   localparam int ACTIVE_W         = 5;
   localparam int HANDLE_W         = 64;
   localparam int WORKER_W         = 4;
   localparam int STATUS_W         = 2;
   localparam int MAX_WORKERS_DEF  = 16;
   localparam int RING_DEPTH_DEF   = 32;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(1);

   localparam logic OP_SUBMIT = 1'b0;
   localparam logic OP_FETCH  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd3;

   typedef struct packed {
      logic                op;
      logic [HANDLE_W-1:0] func_handle;
      logic [HANDLE_W-1:0] data_handle;
      logic [WORKER_W-1:0] worker_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORKER_W-1:0] target_worker;
      logic [HANDLE_W-1:0] out_func_handle;
      logic [HANDLE_W-1:0] out_data_handle;
      logic                all_empty;
   } rsp_type;

   typedef struct packed {
      logic load;       // latch the request
      logic decide;     // pointer check, store access, pointer update
      logic reply;      // build the response
      logic csr_write;  // worker count register write
   } ctl_cmd_type;

endpackage

[rtl/rrjd_ctrl.sv]
// Sequencer for the dispatcher: accept, decide, reply.
module rrjd_ctrl import rrjd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        csr_valid,
   output logic        csr_ready,
   output ctl_cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_REPLY  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (start) state_in = S_DECIDE;
         S_DECIDE: state_in = S_REPLY;
         S_REPLY:  state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign csr_ready     = (state_ff == S_IDLE);
   assign cmd.load      = start && (state_ff == S_IDLE);
   assign cmd.decide    = (state_ff == S_DECIDE);
   assign cmd.reply     = (state_ff == S_REPLY);
   assign cmd.csr_write = csr_valid && csr_ready;

   a_load_to_decide: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_DECIDE))
      else $error("accepted request did not move to decide");

   a_decide_to_reply: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> cmd.reply)
      else $error("decide not followed by reply");

endmodule

[rtl/rrjd_dp.sv]
// Datapath: job store, per-worker ring pointers, round-robin pointer, response.
module rrjd_dp import rrjd_pkg::*; #(
   parameter int MAX_WORKERS = MAX_WORKERS_DEF,
   parameter int RING_DEPTH  = RING_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         cmd,
   input  req_type             req_data,
   input  logic [ACTIVE_W-1:0] csr_wdata,
   output rsp_type             rsp_data,
   output logic                rsp_valid
);

   localparam int WW    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int PW    = $clog2(RING_DEPTH);
   localparam int SLOTS = MAX_WORKERS * RING_DEPTH;
   localparam int AW    = $clog2(SLOTS);
   localparam int CW    = ($clog2(MAX_WORKERS + 1) > ACTIVE_W) ?
                          $clog2(MAX_WORKERS + 1) : ACTIVE_W;
   localparam int JW    = 2 * HANDLE_W;

   logic [ACTIVE_W-1:0]    active_ff;
   logic [CW-1:0]          count;
   logic [MAX_WORKERS-1:0] active_mask;

   req_type                req_ff;
   logic [WW-1:0]          next_ff;
   logic [WW-1:0]          next_in;
   logic [PW-1:0]          wp_ff [MAX_WORKERS];
   logic [PW-1:0]          rp_ff [MAX_WORKERS];
   logic [MAX_WORKERS-1:0] nonempty_ff;

   logic [WW-1:0]          sel;
   logic [CW-1:0]          sel_plus;
   logic [PW-1:0]          cur_wp;
   logic [PW-1:0]          cur_rp;
   logic [PW-1:0]          wp_nxt;
   logic [PW-1:0]          rp_nxt;
   logic                   is_submit;
   logic                   bad_id;
   logic                   submit_ok;
   logic                   fetch_ok;
   logic [STATUS_W-1:0]    status_in;
   logic [WORKER_W-1:0]    target_in;
   logic [AW-1:0]          mem_addr;

   logic [STATUS_W-1:0]    status_ff;
   logic [WORKER_W-1:0]    target_ff;
   logic                   fetch_ok_ff;
   logic [JW-1:0]          rd_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic                   rsp_valid_ff;

   logic [JW-1:0]          mem [SLOTS];

   // zero counts as one, anything above the ring count saturates
   always_comb begin
      if (active_ff == '0) begin
         count = CW'(1);
      end else if (CW'(active_ff) > CW'(MAX_WORKERS)) begin
         count = CW'(MAX_WORKERS);
      end else begin
         count = CW'(active_ff);
      end
      for (int w = 0; w < MAX_WORKERS; w++) begin
         active_mask[w] = (CW'(w) < count);
      end
   end

   always_comb begin
      is_submit = (req_ff.op == OP_SUBMIT);
      if (is_submit) begin
         // stale pointer after the count was lowered falls back to ring 0
         sel = (CW'(next_ff) >= count) ? '0 : next_ff;
      end else begin
         sel = WW'(req_ff.worker_id);
      end
      bad_id   = !is_submit && (CW'(req_ff.worker_id) >= count);
      cur_wp   = wp_ff[sel];
      cur_rp   = rp_ff[sel];
      wp_nxt   = (cur_wp == PW'(RING_DEPTH - 1)) ? '0 : cur_wp + 1'b1;
      rp_nxt   = (cur_rp == PW'(RING_DEPTH - 1)) ? '0 : cur_rp + 1'b1;
      sel_plus = CW'(sel) + CW'(1);
      next_in  = (sel_plus >= count) ? '0 : WW'(sel_plus);

      if (is_submit) begin
         status_in = (wp_nxt == cur_rp) ? ST_FULL : ST_OK;
         target_in = WORKER_W'(sel);
      end else begin
         if (bad_id) begin
            status_in = ST_BAD_ID;
         end else if (cur_wp == cur_rp) begin
            status_in = ST_EMPTY;
         end else begin
            status_in = ST_OK;
         end
         target_in = req_ff.worker_id;
      end
      submit_ok = is_submit && (status_in == ST_OK);
      fetch_ok  = !is_submit && (status_in == ST_OK);
      mem_addr  = AW'(sel) * AW'(RING_DEPTH) + AW'(is_submit ? cur_wp : cur_rp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACTIVE_RESET;
         next_ff      <= '0;
         nonempty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int w = 0; w < MAX_WORKERS; w++) begin
            wp_ff[w] <= '0;
            rp_ff[w] <= '0;
         end
      end else begin
         if (cmd.csr_write) active_ff <= csr_wdata;
         if (cmd.decide && submit_ok) begin
            wp_ff[sel]       <= wp_nxt;
            nonempty_ff[sel] <= 1'b1;
            next_ff          <= next_in;
         end
         if (cmd.decide && fetch_ok) begin
            rp_ff[sel]       <= rp_nxt;
            nonempty_ff[sel] <= (rp_nxt != cur_wp);
         end
         rsp_valid_ff <= cmd.reply;
      end
   end

   // single-port job store, read data registered
   always_ff @(posedge clock) begin
      if (cmd.decide && submit_ok) mem[mem_addr] <= {req_ff.func_handle, req_ff.data_handle};
      rd_ff <= mem[mem_addr];
   end

   always_comb begin
      rsp_in.status          = status_ff;
      rsp_in.target_worker   = target_ff;
      rsp_in.out_func_handle = fetch_ok_ff ? rd_ff[JW-1:HANDLE_W] : '0;
      rsp_in.out_data_handle = fetch_ok_ff ? rd_ff[HANDLE_W-1:0] : '0;
      rsp_in.all_empty       = ((nonempty_ff & active_mask) == '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.decide) begin
         status_ff   <= status_in;
         target_ff   <= target_in;
         fetch_ok_ff <= fetch_ok;
      end
      if (cmd.reply) rsp_ff <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held for more than one cycle");

   a_handles_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != ST_OK)) |->
      ((rsp_ff.out_func_handle == '0) && (rsp_ff.out_data_handle == '0)))
      else $error("handles nonzero on a failed request");

   a_submit_not_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && submit_ok) |=> ((nonempty_ff & active_mask) != '0))
      else $error("accepted submit left every active ring empty");

endmodule

[rtl/round_robin_job_dispatcher.sv]
// A request accepted while idle passes through decide and reply; its result is registered and shown for one cycle.
// No new request is taken until the last one is through (accept, decide with store access, reply).
// The single-port job store and the pointer read-modify-write are why requests do not overlap.
// Reset (synchronous, active high): worker count 1, round-robin pointer and all
// ring pointers zero, every ring empty; the job store is not cleared.
// The result receiver cannot stall; busy is low only while waiting for a request.
module round_robin_job_dispatcher import rrjd_pkg::*; #(
   parameter int MAX_WORKERS = MAX_WORKERS_DEF,
   parameter int RING_DEPTH  = RING_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_valid,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [ACTIVE_W-1:0] csr_wdata
);

   ctl_cmd_type cmd;

   rrjd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   rrjd_dp #(
      .MAX_WORKERS (MAX_WORKERS),
      .RING_DEPTH  (RING_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid)
   );

endmodule

[dv/tb_round_robin_job_dispatcher.sv]
// Self-checking testbench for the round-robin job dispatcher: queued driver, predicting monitor.
module tb_round_robin_job_dispatcher import rrjd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORKERS    = MAX_WORKERS_DEF;
   localparam int RING       = RING_DEPTH_DEF;
   localparam int IDLE_LIMIT = 500;
   localparam int MAX_REPORT = 40;

   typedef enum logic [1:0] {STEP_JOB, STEP_COUNT, STEP_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type       kind;
      req_type             req;
      logic [ACTIVE_W-1:0] wdata;
      int unsigned         gap;
   } stim_step_type;

   logic                clock;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                busy;
   req_type             req_data  = '0;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [ACTIVE_W-1:0] csr_wdata = '0;

   round_robin_job_dispatcher i_dut (
      .clock,
      .reset,
      .start,
      .busy,
      .req_data,
      .rsp_valid,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_wdata
   );

   // Predicted dispatcher state
   logic [HANDLE_W-1:0] func_mem [WORKERS*RING];
   logic [HANDLE_W-1:0] data_mem [WORKERS*RING];
   logic [4:0]          wr_ptr [WORKERS] = '{default: '0};
   logic [4:0]          rd_ptr [WORKERS] = '{default: '0};
   logic [WORKER_W-1:0] rr_next     = '0;
   logic [ACTIVE_W-1:0] worker_cnt  = ACTIVE_RESET;

   rsp_type        rsp_expected_q [$];
   stim_step_type  job_q [$];
   int unsigned err_cnt   = 0;
   int unsigned idle_cyc  = 0;
   int unsigned gap_left  = 0;
   int unsigned job_total = 0;
   bit          no_idle   = 1'b0;
   logic        req_taken = 1'b0;
   logic        csr_taken = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   function automatic int eff_count(logic [ACTIVE_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > WORKERS) return WORKERS;
      return int'(raw);
   endfunction

   function automatic logic [4:0] ring_step(logic [4:0] p);
      return (p == RING - 1) ? 5'd0 : p + 5'd1;
   endfunction

   task automatic predict_dispatch(input req_type r, output rsp_type o);
      int n;
      int tgt;
      int slot;
      logic [4:0] nxt;
      n = eff_count(worker_cnt);
      o = '0;
      o.status = ST_OK;
      if (r.op == OP_SUBMIT) begin
         tgt = (int'(rr_next) >= n) ? 0 : int'(rr_next);
         nxt = ring_step(wr_ptr[tgt]);
         if (nxt == rd_ptr[tgt]) begin
            o.status = ST_FULL;
         end else begin
            slot = tgt * RING + int'(wr_ptr[tgt]);
            func_mem[slot] = r.func_handle;
            data_mem[slot] = r.data_handle;
            wr_ptr[tgt] = nxt;
            rr_next = (tgt + 1 >= n) ? '0 : WORKER_W'(tgt + 1);
         end
      end else begin
         tgt = int'(r.worker_id);
         if (tgt >= n) begin
            o.status = ST_BAD_ID;
         end else if (wr_ptr[tgt] == rd_ptr[tgt]) begin
            o.status = ST_EMPTY;
         end else begin
            slot = tgt * RING + int'(rd_ptr[tgt]);
            o.out_func_handle = func_mem[slot];
            o.out_data_handle = data_mem[slot];
            rd_ptr[tgt] = ring_step(rd_ptr[tgt]);
         end
      end
      o.target_worker = WORKER_W'(tgt);
      o.all_empty = 1'b1;
      for (int w = 0; w < n; w++) begin
         if (wr_ptr[w] != rd_ptr[w]) o.all_empty = 1'b0;
      end
   endtask

   function automatic void flag_field(string name, logic [HANDLE_W-1:0] want,
                                      logic [HANDLE_W-1:0] got);
      err_cnt++;
      if (err_cnt <= MAX_REPORT)
         $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
   endfunction

   // Driver: one step at a time, inputs change on the falling edge
   always @(negedge clock) begin : drive_proc
      logic start_n;
      logic csr_n;
      start_n = start;
      csr_n   = csr_valid;
      if (start && req_taken) start_n = 1'b0;
      if (csr_valid && csr_taken) csr_n = 1'b0;
      if (!reset && !start_n && !csr_n) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (job_q.size() > 0) begin
            case (job_q[0].kind)
               STEP_JOB: begin
                  req_data <= job_q[0].req;
                  start_n  = 1'b1;
                  gap_left = job_q[0].gap;
                  void'(job_q.pop_front());
               end
               STEP_COUNT: begin
                  if (rsp_expected_q.size() == 0) begin
                     csr_wdata <= job_q[0].wdata;
                     csr_n = 1'b1;
                     void'(job_q.pop_front());
                  end
               end
               default: begin
                  if (rsp_expected_q.size() == 0) void'(job_q.pop_front());
               end
            endcase
         end
      end
      start     <= start_n;
      csr_valid <= csr_n;
   end

   // Monitor: checks results, predicts on each accepted transfer
   always @(posedge clock) begin : mon_proc
      rsp_type want;
      req_taken <= !reset && start && !busy;
      csr_taken <= !reset && csr_valid && csr_ready;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (rsp_expected_q.size() == 0) begin
               flag_field("unexpected result", '0, rsp_data.out_func_handle);
            end else begin
               want = rsp_expected_q.pop_front();
               if (rsp_data.status !== want.status)
                  flag_field("status", HANDLE_W'(want.status), HANDLE_W'(rsp_data.status));
               if (rsp_data.target_worker !== want.target_worker)
                  flag_field("target_worker", HANDLE_W'(want.target_worker),
                             HANDLE_W'(rsp_data.target_worker));
               if (rsp_data.out_func_handle !== want.out_func_handle)
                  flag_field("out_func_handle", want.out_func_handle,
                             rsp_data.out_func_handle);
               if (rsp_data.out_data_handle !== want.out_data_handle)
                  flag_field("out_data_handle", want.out_data_handle,
                             rsp_data.out_data_handle);
               if (rsp_data.all_empty !== want.all_empty)
                  flag_field("all_empty", HANDLE_W'(want.all_empty),
                             HANDLE_W'(rsp_data.all_empty));
            end
         end
         if (start && busy === 1'b0) begin
            predict_dispatch(req_data, want);
            rsp_expected_q.push_back(want);
         end
         if (csr_valid && csr_ready === 1'b1) worker_cnt = csr_wdata;
         if ((start && busy === 1'b0) || rsp_valid === 1'b1 ||
             (csr_valid && csr_ready === 1'b1))
            idle_cyc = 0;
         else
            idle_cyc++;
         if (idle_cyc >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired", $realtime);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic logic [HANDLE_W-1:0] rand_handle();
      return {$urandom, $urandom};
   endfunction

   function automatic void push_job(logic op, logic [HANDLE_W-1:0] fh,
                                    logic [HANDLE_W-1:0] dh, int wid);
      stim_step_type s;
      int unsigned r;
      s.kind  = STEP_JOB;
      s.req.op          = op;
      s.req.func_handle = fh;
      s.req.data_handle = dh;
      s.req.worker_id   = WORKER_W'(wid);
      s.wdata = '0;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) s.gap = 0;
      else if (r < 90) s.gap = $urandom_range(1, 3);
      else s.gap = $urandom_range(6, 40);
      job_q.push_back(s);
      job_total++;
   endfunction

   function automatic void push_count(int v);
      stim_step_type s;
      s.kind  = STEP_COUNT;
      s.req   = '0;
      s.wdata = ACTIVE_W'(v);
      s.gap   = 0;
      job_q.push_back(s);
   endfunction

   function automatic void push_drain();
      stim_step_type s;
      s.kind  = STEP_DRAIN;
      s.req   = '0;
      s.wdata = '0;
      s.gap   = 0;
      job_q.push_back(s);
   endfunction

   initial begin : stim_proc
      int style;
      int v;
      int n;
      int len;
      int sub_pct;
      int wid;

      // Directed: empty and bad-id fetches, handle extremes, count extremes, stale pointer
      push_job(OP_FETCH, rand_handle(), rand_handle(), 0);
      push_job(OP_FETCH, rand_handle(), rand_handle(), 15);
      push_job(OP_SUBMIT, '1, '1, $urandom_range(0, 15));
      push_job(OP_SUBMIT, '0, '0, $urandom_range(0, 15));
      push_job(OP_FETCH, '0, '0, 0);
      push_job(OP_FETCH, '1, '1, 0);
      push_job(OP_FETCH, rand_handle(), rand_handle(), 0);
      push_count(0);
      push_job(OP_SUBMIT, {16{4'h5}}, {16{4'hA}}, 15);
      push_job(OP_FETCH, rand_handle(), rand_handle(), 1);
      push_job(OP_FETCH, rand_handle(), rand_handle(), 0);
      push_count(31);
      repeat (3) push_job(OP_SUBMIT, rand_handle(), rand_handle(), $urandom_range(0, 15));
      push_job(OP_FETCH, rand_handle(), rand_handle(), 15);
      // lowering the count leaves the round-robin pointer at 3
      push_count(2);
      push_job(OP_FETCH, rand_handle(), rand_handle(), 2);
      push_job(OP_SUBMIT, rand_handle(), rand_handle(), $urandom_range(0, 15));
      push_count(16);
      push_job(OP_FETCH, rand_handle(), rand_handle(), 2);
      push_job(OP_FETCH, rand_handle(), rand_handle(), 0);
      push_job(OP_FETCH, rand_handle(), rand_handle(), 0);
      push_job(OP_FETCH, rand_handle(), rand_handle(), 1);
      push_job(OP_FETCH, rand_handle(), rand_handle(), 1);
      push_drain();

      // Random phases: fill-heavy, drain-heavy or mixed, each with its own worker count
      while (job_total < 1620) begin
         style = $urandom_range(0, 2);
         if (style == 0 && $urandom_range(0, 3) != 0) begin
            v = $urandom_range(1, 3);
         end else begin
            case ($urandom_range(0, 5))
               0: v = 0;
               1: v = 31;
               2: v = 16;
               3: v = 1;
               default: v = $urandom_range(0, 31);
            endcase
         end
         push_count(v);
         n = eff_count(ACTIVE_W'(v));
         no_idle = ($urandom_range(0, 3) == 0);
         sub_pct = (style == 0) ? 85 : (style == 1) ? 15 : 50;
         len = $urandom_range(30, 120);
         repeat (len) begin
            if ($urandom_range(0, 99) < sub_pct) begin
               push_job(OP_SUBMIT, rand_handle(), rand_handle(), $urandom_range(0, 15));
            end else begin
               wid = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, n - 1);
               push_job(OP_FETCH, rand_handle(), rand_handle(), wid);
            end
         end
         if ($urandom_range(0, 2) == 0) push_drain();
      end
      no_idle = 1'b0;

      while (reset || job_q.size() > 0 || start || csr_valid) @(posedge clock);
      while (rsp_expected_q.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (err_cnt == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
rtl/rrjd_pkg.sv
rtl/rrjd_ctrl.sv
rtl/rrjd_dp.sv
rtl/round_robin_job_dispatcher.sv
dv/tb_round_robin_job_dispatcher.sv
